// ===== hw/rtl/nbss_pkg.sv =====
// ----------------------------------------------------------------------------
// nbss_pkg: shared types and constants of the NetBIOS/SMB message framer
// Request and result payload types, status codes and the segment offset limit.
// ----------------------------------------------------------------------------
package nbss_pkg;

    // Status codes of one result.
    localparam logic [1:0] ST_SEARCH = 2'd0;
    localparam logic [1:0] ST_FLUSH  = 2'd1;
    localparam logic [1:0] ST_ABORT  = 2'd2;

    localparam int unsigned OFS_W = 16;
    localparam int unsigned FP_W  = 18;

    // Largest segment size; offsets at or above it are clamped to one below it.
    localparam longint unsigned SEG_BYTES_MAX = 65535;
    localparam logic [OFS_W-1:0] OFS_LIMIT =
        (SEG_BYTES_MAX - 1 > 65535) ? 16'hFFFF : OFS_W'(SEG_BYTES_MAX - 1);

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [OFS_W-1:0] byte_offset;
        logic             session_abort;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [FP_W-1:0] flush_point;
    } t_out_item;

endpackage

// ===== hw/rtl/nbss_in_if.sv =====
// ----------------------------------------------------------------------------
// nbss_in_if: byte request channel
// Valid/ready channel carrying one stream byte with its offset and abort flag.
// ----------------------------------------------------------------------------
interface nbss_in_if;
    logic                     valid;
    logic                     ready;
    logic [7:0]               data_byte;
    logic [nbss_pkg::OFS_W-1:0] byte_offset;
    logic                     session_abort;

    modport source (output valid, data_byte, byte_offset, session_abort, input ready);
    modport sink   (input valid, data_byte, byte_offset, session_abort, output ready);
endinterface

// ===== hw/rtl/nbss_out_if.sv =====
// ----------------------------------------------------------------------------
// nbss_out_if: framer result channel
// Valid/ready channel carrying the status and flush point of one request.
// ----------------------------------------------------------------------------
interface nbss_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [nbss_pkg::FP_W-1:0] flush_point;

    modport source (output valid, status, flush_point, input ready);
    modport sink   (input valid, status, flush_point, output ready);
endinterface

// ===== hw/rtl/nbss_in_stage.sv =====
// ----------------------------------------------------------------------------
// nbss_in_stage: request input register
// Captures one request per cycle while the result stage does not stall it, and clamps its offset to the segment limit.
// ----------------------------------------------------------------------------
module nbss_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nbss_in_if.sink            i_req,
    input  logic               i_adv,
    output logic               o_valid,
    output nbss_pkg::t_in_item o_item
);
    import nbss_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    t_in_item n_item;

    assign i_req.ready = !r_valid || i_adv;

    always_comb begin
        n_item.data_byte     = i_req.data_byte;
        n_item.session_abort = i_req.session_abort;
        n_item.byte_offset   = (i_req.byte_offset > OFS_LIMIT) ? OFS_LIMIT
                                                               : i_req.byte_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== hw/rtl/nbss_parser.sv =====
// ----------------------------------------------------------------------------
// nbss_parser: session header state machine
// Holds the parse state and header window and computes one result per byte.
// ----------------------------------------------------------------------------
module nbss_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  nbss_pkg::t_in_item  i_item,
    output nbss_pkg::t_out_item o_res
);
    import nbss_pkg::*;

    localparam logic [2:0] PS_TYPE   = 3'd0;
    localparam logic [2:0] PS_FLAG   = 3'd1;
    localparam logic [2:0] PS_LEN_HI = 3'd2;
    localparam logic [2:0] PS_LEN_LO = 3'd3;
    localparam logic [2:0] PS_JUNK0  = 3'd4;
    localparam logic [2:0] PS_JUNK1  = 3'd5;
    localparam logic [2:0] PS_JUNK2  = 3'd6;
    localparam logic [2:0] PS_JUNK3  = 3'd7;

    localparam logic [31:0] SMB1_MAGIC = 32'hFF534D42;
    localparam logic [31:0] SMB2_MAGIC = 32'hFE534D42;
    localparam logic [2:0]  BACK_HDR   = 3'd3;
    localparam logic [2:0]  BACK_JUNK  = 3'd7;

    function automatic logic hdr_ok(input logic [31:0] hdr, input logic junk);
        logic [7:0] kind;
        logic [7:0] flag;
        logic       kind_ok;
        kind    = hdr[31:24];
        flag    = hdr[23:16];
        kind_ok = (kind == 8'h00) ||
                  (!junk && (kind >= 8'h81) && (kind <= 8'h85));
        return kind_ok && ((flag == 8'h00) || (flag == 8'h01));
    endfunction

    // Length plus four plus offset, minus the header distance; floors at zero.
    function automatic logic [FP_W-1:0] flush_at(input logic [31:0]      hdr,
                                                 input logic [OFS_W-1:0] ofs,
                                                 input logic [2:0]       back);
        logic [FP_W-1:0] sum;
        sum = {1'b0, hdr[16:0]} + FP_W'(4) + {2'b00, ofs};
        return (sum < {15'd0, back}) ? '0 : sum - {15'd0, back};
    endfunction

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [63:0] r_window;
    logic [63:0] n_window;
    logic [63:0] shifted;

    assign shifted = {r_window[55:0], i_item.data_byte};

    always_comb begin
        n_state           = r_state;
        n_window          = r_window;
        o_res.status      = ST_SEARCH;
        o_res.flush_point = '0;
        if (i_item.session_abort) begin
            o_res.status = ST_ABORT;
        end else begin
            unique case (r_state)
                PS_TYPE: begin
                    n_window = {56'd0, i_item.data_byte};
                    n_state  = PS_FLAG;
                end
                PS_LEN_LO: begin
                    n_window = shifted;
                    if (hdr_ok(shifted[31:0], 1'b0)) begin
                        o_res.status      = ST_FLUSH;
                        o_res.flush_point = flush_at(shifted[31:0],
                                                     i_item.byte_offset, BACK_HDR);
                        n_state           = PS_TYPE;
                    end else begin
                        n_state = PS_JUNK0;
                    end
                end
                PS_JUNK3: begin
                    // Resync needs a plain session message header and an SMB id.
                    n_window = shifted;
                    if (hdr_ok(shifted[63:32], 1'b1) &&
                        ((shifted[31:0] == SMB1_MAGIC) ||
                         (shifted[31:0] == SMB2_MAGIC))) begin
                        o_res.status      = ST_FLUSH;
                        o_res.flush_point = flush_at(shifted[63:32],
                                                     i_item.byte_offset, BACK_JUNK);
                        n_state           = PS_TYPE;
                    end
                end
                PS_FLAG, PS_LEN_HI, PS_JUNK0, PS_JUNK1, PS_JUNK2: begin
                    n_window = shifted;
                    n_state  = r_state + 3'd1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= PS_TYPE;
            r_window <= '0;
        end else if (i_go) begin
            r_state  <= n_state;
            r_window <= n_window;
        end
    end
endmodule

// ===== hw/rtl/netbios_smb_message_framer.sv =====
// ----------------------------------------------------------------------------
// netbios_smb_message_framer: NetBIOS session message framer for SMB streams
// Walks the 4-byte session header and reports message-end flush points.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                                   | handshake
//   i_req    | in  | data_byte, byte_offset, session_abort     | valid/ready
//   o_rsp    | out | status, flush_point                       | valid/ready
//
// One request per cycle while the result is not stalled; each result passes
// through the input register, then the result register.
// Reset clears the parse state, the header window and both valid flags.
// A stalled result holds the pipeline; the input register still takes a
// request while it is empty.
// ----------------------------------------------------------------------------
module netbios_smb_message_framer (
    input  logic i_clk,
    input  logic i_rst_n,
    nbss_in_if.sink    i_req,
    nbss_out_if.source o_rsp
);
    import nbss_pkg::*;

    logic      adv;
    logic      in_valid;
    t_in_item  in_item;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out;

    assign adv = !r_out_valid || o_rsp.ready;

    nbss_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    nbss_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (in_valid && adv),
        .i_item  (in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && in_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.flush_point = r_out.flush_point;
endmodule

// ===== hw/rtl/nbss_checker.sv =====
// ----------------------------------------------------------------------------
// nbss_checker: port-level checks of the framer
// Watches the result channel for legal codes, bounds and held payloads.
// ----------------------------------------------------------------------------
module nbss_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_rsp_valid,
    input logic                      i_rsp_ready,
    input logic [1:0]                i_rsp_status,
    input logic [nbss_pkg::FP_W-1:0] i_rsp_flush_point
);
    import nbss_pkg::*;

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == ST_SEARCH || i_rsp_status == ST_FLUSH ||
                         i_rsp_status == ST_ABORT))
        else $error("framer result carries an unknown status code");

    a_fp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != ST_FLUSH) |-> (i_rsp_flush_point == '0))
        else $error("flush point is nonzero without a flush status");

    a_fp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == ST_FLUSH) |-> (i_rsp_flush_point <= 18'd196607))
        else $error("flush point exceeds the largest message end");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_flush_point)))
        else $error("stalled result changed");
endmodule

bind netbios_smb_message_framer nbss_checker u_nbss_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_flush_point (o_rsp.flush_point)
);
